// File: rtl/mdc_pkg.sv
// ---------------------------------------------------------------------------
// mdc_pkg
// Shared types, codes and tables of the depth-first maze carver.
// ---------------------------------------------------------------------------
package mdc_pkg;

    // Default grid limits in rooms.
    localparam int MDC_MAX_ROOM_ROWS = 32;
    localparam int MDC_MAX_ROOM_COLS = 32;

    // Configuration registers.
    localparam int          CFG_W        = 6;
    localparam logic [5:0]  DIM_RESET    = 6'd8;
    localparam int          APB_AW       = 3;
    localparam int          APB_DW       = 32;
    localparam logic        REG_SEL_ROWS = 1'b0;
    localparam logic        REG_SEL_COLS = 1'b1;

    // Item opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Result events.
    localparam logic [1:0] EV_STARTED   = 2'd0;
    localparam logic [1:0] EV_CARVED    = 2'd1;
    localparam logic [1:0] EV_BACKTRACK = 2'd2;
    localparam logic [1:0] EV_DONE      = 2'd3;

    // Directions.
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [1:0] event_res;
        logic [4:0] room_row;
        logic [4:0] room_col;
        logic [1:0] direction;
    } mdc_result_t;

    // Lexicographic permutations of right, up, left, down. The first
    // direction to try sits in bits [1:0], the last in bits [7:6].
    // Indices 24 to 31 fold back onto 0 to 7.
    function automatic logic [7:0] perm_order(input logic [4:0] idx);
        logic [4:0] w;
        logic [7:0] o;
        begin
            w = (idx >= 5'd24) ? idx - 5'd24 : idx;
            unique case (w)
                5'd0:    o = 8'hE4;
                5'd1:    o = 8'hB4;
                5'd2:    o = 8'hD8;
                5'd3:    o = 8'h78;
                5'd4:    o = 8'h9C;
                5'd5:    o = 8'h6C;
                5'd6:    o = 8'hE1;
                5'd7:    o = 8'hB1;
                5'd8:    o = 8'hC9;
                5'd9:    o = 8'h39;
                5'd10:   o = 8'h8D;
                5'd11:   o = 8'h2D;
                5'd12:   o = 8'hD2;
                5'd13:   o = 8'h72;
                5'd14:   o = 8'hC6;
                5'd15:   o = 8'h36;
                5'd16:   o = 8'h4E;
                5'd17:   o = 8'h1E;
                5'd18:   o = 8'h93;
                5'd19:   o = 8'h63;
                5'd20:   o = 8'h87;
                5'd21:   o = 8'h27;
                5'd22:   o = 8'h4B;
                5'd23:   o = 8'h1B;
                default: o = 8'hE4;
            endcase
            perm_order = o;
        end
    endfunction

endpackage

// File: rtl/mdc_cfg_regs.sv
// ---------------------------------------------------------------------------
// mdc_cfg_regs
// APB register file holding the room rows and columns in use, with the
// clamped grid dimensions as outputs.
// ---------------------------------------------------------------------------
module mdc_cfg_regs
    import mdc_pkg::*;
#(
    parameter  int MAX_ROOM_ROWS = MDC_MAX_ROOM_ROWS,
    parameter  int MAX_ROOM_COLS = MDC_MAX_ROOM_COLS,
    localparam int RDW           = $clog2(MAX_ROOM_ROWS + 1),
    localparam int CDW           = $clog2(MAX_ROOM_COLS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [RDW-1:0]    rows_dim,
    output logic [CDW-1:0]    cols_dim
);

    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // The word address selects the register; the byte offset is ignored.
    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en) begin
            if (paddr[2] == REG_SEL_ROWS) begin
                rows_next = pwdata[CFG_W-1:0];
            end else begin
                cols_next = pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEL_ROWS: prdata = APB_DW'(rows_reg);
            REG_SEL_COLS: prdata = APB_DW'(cols_reg);
            default:      prdata = '0;
        endcase
    end

    // Zero acts as one; anything above the grid limit acts as the limit.
    always_comb begin
        if (rows_reg == '0) begin
            rows_dim = RDW'(1);
        end else if (32'(rows_reg) > 32'(MAX_ROOM_ROWS)) begin
            rows_dim = RDW'(MAX_ROOM_ROWS);
        end else begin
            rows_dim = RDW'(rows_reg);
        end
        if (cols_reg == '0) begin
            cols_dim = CDW'(1);
        end else if (32'(cols_reg) > 32'(MAX_ROOM_COLS)) begin
            cols_dim = CDW'(MAX_ROOM_COLS);
        end else begin
            cols_dim = CDW'(cols_reg);
        end
    end

endmodule

// File: rtl/mdc_nbr.sv
// ---------------------------------------------------------------------------
// mdc_nbr
// Neighbor room of the current room in one direction, and whether it lies
// inside the grid.
// ---------------------------------------------------------------------------
module mdc_nbr
    import mdc_pkg::*;
#(
    parameter  int MAX_ROOM_ROWS = MDC_MAX_ROOM_ROWS,
    parameter  int MAX_ROOM_COLS = MDC_MAX_ROOM_COLS,
    localparam int RW            = $clog2(MAX_ROOM_ROWS),
    localparam int CW            = $clog2(MAX_ROOM_COLS),
    localparam int RDW           = $clog2(MAX_ROOM_ROWS + 1),
    localparam int CDW           = $clog2(MAX_ROOM_COLS + 1)
) (
    input  logic [RW-1:0]  row,
    input  logic [CW-1:0]  col,
    input  logic [RDW-1:0] rows_dim,
    input  logic [CDW-1:0] cols_dim,
    input  logic [1:0]     dir,
    output logic           nbr_ok,
    output logic [RW-1:0]  nbr_row,
    output logic [CW-1:0]  nbr_col
);

    logic [31:0] row_up, row_dn, col_up, col_dn;

    assign row_up = 32'(row) + 32'd1;
    assign row_dn = 32'(row) - 32'd1;
    assign col_up = 32'(col) + 32'd1;
    assign col_dn = 32'(col) - 32'd1;

    always_comb begin
        nbr_row = row;
        nbr_col = col;
        nbr_ok  = 1'b0;
        unique case (dir)
            DIR_RIGHT: begin
                nbr_col = CW'(col_up);
                nbr_ok  = col_up < 32'(cols_dim);
            end
            DIR_UP: begin
                nbr_row = RW'(row_dn);
                nbr_ok  = (row != '0) && (row_dn < 32'(rows_dim));
            end
            DIR_LEFT: begin
                nbr_col = CW'(col_dn);
                nbr_ok  = (col != '0) && (col_dn < 32'(cols_dim));
            end
            DIR_DOWN: begin
                nbr_row = RW'(row_up);
                nbr_ok  = row_up < 32'(rows_dim);
            end
            default: begin
                nbr_ok = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/mdc_carver.sv
// ---------------------------------------------------------------------------
// mdc_carver
// Carving sequencer: carved-room map and room stack memories, the step state
// machine around them and the result register.
// ---------------------------------------------------------------------------
module mdc_carver
    import mdc_pkg::*;
#(
    parameter  int MAX_ROOM_ROWS = MDC_MAX_ROOM_ROWS,
    parameter  int MAX_ROOM_COLS = MDC_MAX_ROOM_COLS,
    localparam int RW            = $clog2(MAX_ROOM_ROWS),
    localparam int CW            = $clog2(MAX_ROOM_COLS),
    localparam int RDW           = $clog2(MAX_ROOM_ROWS + 1),
    localparam int CDW           = $clog2(MAX_ROOM_COLS + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_opcode,
    input  logic [4:0]     in_perm,
    input  logic [RDW-1:0] rows_dim,
    input  logic [CDW-1:0] cols_dim,
    output logic           out_valid,
    input  logic           out_ready,
    output mdc_result_t    out_res
);

    localparam int AW         = RW + CW;
    localparam int ROOM_COUNT = MAX_ROOM_ROWS * MAX_ROOM_COLS;
    localparam int SIW        = $clog2(ROOM_COUNT);
    localparam int DW         = $clog2(ROOM_COUNT + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;
    localparam logic [2:0] ST_POP_RD = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    k_reg, k_next;
    logic [7:0]    order_reg, order_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] cand_reg, cand_next;
    logic [1:0]    cand_dir_reg, cand_dir_next;
    logic [AW-1:0] clr_reg, clr_next;
    mdc_result_t   res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    mdc_result_t   out_res_reg, out_res_next;

    // Carved map: one bit per room, addressed by {row, col}.
    logic          map_mem [2**AW];
    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic          map_wdata;
    logic [AW-1:0] map_raddr;
    logic          map_rdata_reg;

    // Room stack, entries {row, col}.
    logic [AW-1:0]  stack_mem [ROOM_COUNT];
    logic           stack_we;
    logic [SIW-1:0] stack_waddr;
    logic [AW-1:0]  stack_wdata;
    logic [SIW-1:0] stack_raddr;
    logic [AW-1:0]  stack_rdata_reg;

    logic          nbr_ok;
    logic [RW-1:0] nbr_row;
    logic [CW-1:0] nbr_col;
    logic [1:0]    cur_dir;

    assign cur_dir = order_reg[{k_reg, 1'b0} +: 2];

    mdc_nbr #(
        .MAX_ROOM_ROWS (MAX_ROOM_ROWS),
        .MAX_ROOM_COLS (MAX_ROOM_COLS)
    ) u_nbr (
        .row      (top_reg[AW-1:CW]),
        .col      (top_reg[CW-1:0]),
        .rows_dim (rows_dim),
        .cols_dim (cols_dim),
        .dir      (cur_dir),
        .nbr_ok   (nbr_ok),
        .nbr_row  (nbr_row),
        .nbr_col  (nbr_col)
    );

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    // Each item runs to completion before the next is taken, so a map or
    // stack write always lands before any later read of the same entry.
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        order_next     = order_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        cand_next      = cand_reg;
        cand_dir_next  = cand_dir_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;

        map_we      = 1'b0;
        map_waddr   = cand_reg;
        map_wdata   = 1'b1;
        map_raddr   = {nbr_row, nbr_col};
        stack_we    = 1'b0;
        stack_waddr = depth_reg[SIW-1:0];
        stack_wdata = cand_reg;
        stack_raddr = SIW'(depth_reg - DW'(2));

        in_ready = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_opcode == OP_START) begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else if (depth_reg == '0) begin
                        res_next   = '{EV_DONE, 5'd0, 5'd0, DIR_RIGHT};
                        state_next = ST_EMIT;
                    end else begin
                        order_next = perm_order(in_perm);
                        k_next     = 2'd0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_CLEAR: begin
                // Room (0,0) is marked carved as the sweep passes it.
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = (clr_reg == '0);
                if (clr_reg == '1) begin
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = '0;
                    depth_next  = DW'(1);
                    top_next    = '0;
                    res_next    = '{EV_STARTED, 5'd0, 5'd0, DIR_RIGHT};
                    state_next  = ST_EMIT;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_PROBE: begin
                if (nbr_ok) begin
                    cand_next     = {nbr_row, nbr_col};
                    cand_dir_next = cur_dir;
                    state_next    = ST_CHECK;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_POP;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_CHECK: begin
                if (!map_rdata_reg) begin
                    map_we = 1'b1;
                    if (depth_reg < DW'(ROOM_COUNT)) begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + DW'(1);
                        top_next   = cand_reg;
                    end
                    res_next   = '{EV_CARVED, 5'(cand_reg[AW-1:CW]),
                                   5'(cand_reg[CW-1:0]), cand_dir_reg};
                    state_next = ST_EMIT;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_POP;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_PROBE;
                end
            end
            ST_POP: begin
                depth_next = depth_reg - DW'(1);
                if (depth_reg == DW'(1)) begin
                    res_next   = '{EV_DONE, 5'd0, 5'd0, DIR_RIGHT};
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                top_next   = stack_rdata_reg;
                res_next   = '{EV_BACKTRACK, 5'(stack_rdata_reg[AW-1:CW]),
                               5'(stack_rdata_reg[CW-1:0]), DIR_RIGHT};
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        order_reg    <= order_next;
        top_reg      <= top_next;
        cand_reg     <= cand_next;
        cand_dir_reg <= cand_dir_next;
        clr_reg      <= clr_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// File: rtl/maze_dfs_carver_top.sv
// ---------------------------------------------------------------------------
// maze_dfs_carver_top
// Depth-first maze carver with a stream command input, a stream event output
// and an APB register port for the grid size.
// ---------------------------------------------------------------------------
// One item is processed at a time and every item yields exactly one result.
// A start command sweeps the carved-room map once, one entry per cycle, over
// all 2**(clog2(MAX_ROOM_ROWS)+clog2(MAX_ROOM_COLS)) entries. A step tests
// its candidate neighbors in the given order through the single read port of
// the map memory: a neighbor outside the grid is passed over in the probe
// state, and one inside it has its map entry read in the probe state and
// checked in the check state. When no neighbor can be carved, a backtrack
// pops the stack and then reads the new top from the stack memory; a step
// that pops the last room skips the read. A step with an empty stack goes
// straight to the result register. The next command is taken while the
// previous result still waits on the output.
module maze_dfs_carver_top
    import mdc_pkg::*;
#(
    parameter int MAX_ROOM_ROWS = MDC_MAX_ROOM_ROWS,
    parameter int MAX_ROOM_COLS = MDC_MAX_ROOM_COLS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [4:0] perm_index, [7:5] zero
    input  logic [0:0]        s_tuser,   // [0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [4:0] room_row, [9:5] room_col,
                                         // [11:10] direction, [15:12] zero
    output logic [1:0]        m_tuser,   // [1:0] event_res
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int RDW = $clog2(MAX_ROOM_ROWS + 1);
    localparam int CDW = $clog2(MAX_ROOM_COLS + 1);

    logic [RDW-1:0] rows_dim;
    logic [CDW-1:0] cols_dim;
    mdc_result_t    res;

    mdc_cfg_regs #(
        .MAX_ROOM_ROWS (MAX_ROOM_ROWS),
        .MAX_ROOM_COLS (MAX_ROOM_COLS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rows_dim (rows_dim),
        .cols_dim (cols_dim)
    );

    mdc_carver #(
        .MAX_ROOM_ROWS (MAX_ROOM_ROWS),
        .MAX_ROOM_COLS (MAX_ROOM_COLS)
    ) u_carver (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser[0]),
        .in_perm   (s_tdata[4:0]),
        .rows_dim  (rows_dim),
        .cols_dim  (cols_dim),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'b0, res.direction, res.room_col, res.room_row};
    assign m_tuser = res.event_res;

    // Commands are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while the previous one is still in work");

    // Only a carve carries a direction.
    a_dir_only_carve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != EV_CARVED) |-> (m_tdata[11:10] == DIR_RIGHT))
        else $error("direction set on a result that is not a carve");

    // Start, finish and idle results carry no room.
    a_empty_room: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == EV_STARTED) || (m_tuser == EV_DONE))
        |-> (m_tdata == '0))
        else $error("room fields set on a start or finish result");

endmodule

// File: bench/maze_dfs_carver_top_tb.sv
// ---------------------------------------------------------------------------
// maze_dfs_carver_top_tb
// Self-checking bench for the depth-first maze carver. Commands go in on the
// input stream and the grid size is set over APB. A scoreboard keeps its own
// carved map and room stack, predicts the event of every accepted command
// and compares the events that come back, one field at a time.
// ---------------------------------------------------------------------------
module maze_dfs_carver_top_tb;
    import mdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ROOM_TOTAL  = MDC_MAX_ROOM_ROWS * MDC_MAX_ROOM_COLS;
    localparam logic [APB_AW-1:0] ROWS_ADDR = 3'd0;
    localparam logic [APB_AW-1:0] COLS_ADDR = 3'd4;

    class carve_scoreboard;
        logic [5:0]  rows_reg;
        logic [5:0]  cols_reg;
        bit          carved[ROOM_TOTAL];
        int          stack_rooms[ROOM_TOTAL];
        int          depth;
        mdc_result_t expected_events[$];
        int          failures;
        int          event_tally[4];

        function new();
            rows_reg = DIM_RESET;
            cols_reg = DIM_RESET;
            depth    = 0;
            failures = 0;
            foreach (carved[i]) carved[i] = 1'b0;
            foreach (event_tally[i]) event_tally[i] = 0;
        endfunction

        function void set_dim(logic sel, logic [5:0] value);
            if (sel == REG_SEL_ROWS) rows_reg = value;
            else cols_reg = value;
        endfunction

        // Zero behaves as one room, anything past the grid as the grid edge.
        function int span(logic [5:0] value, int limit);
            if (value == 6'd0) return 1;
            if (int'(value) > limit) return limit;
            return int'(value);
        endfunction

        // Factorial-base decode of a lexicographic order of the four
        // directions; the first direction to try lands in bits [1:0].
        function logic [7:0] decode_order(int idx);
            logic [1:0] pool[4];
            logic [7:0] order;
            int         left, pick, f, k, m;
            pool  = '{DIR_RIGHT, DIR_UP, DIR_LEFT, DIR_DOWN};
            order = '0;
            left  = 4;
            f     = 6;
            for (k = 0; k < 3; k++) begin
                pick = idx / f;
                idx  = idx % f;
                order[2*k +: 2] = pool[pick];
                for (m = pick; m < left - 1; m++) pool[m] = pool[m + 1];
                left--;
                f = f / (3 - k);
            end
            order[7:6] = pool[0];
            return order;
        endfunction

        function void note_command(logic op, logic [4:0] perm);
            mdc_result_t res;
            logic [7:0]  order;
            logic [1:0]  d;
            int          rows, cols, idx, top, r, c, nr, nc, k, slot;
            bit          ok, found;
            res = '0;
            if (op == OP_START) begin
                foreach (carved[i]) carved[i] = 1'b0;
                carved[0]      = 1'b1;
                stack_rooms[0] = 0;
                depth          = 1;
                res.event_res  = EV_STARTED;
            end else if (depth == 0) begin
                res.event_res = EV_DONE;
            end else begin
                rows  = span(rows_reg, MDC_MAX_ROOM_ROWS);
                cols  = span(cols_reg, MDC_MAX_ROOM_COLS);
                idx   = int'(perm);
                if (idx >= 24) idx -= 24;
                order = decode_order(idx);
                top   = stack_rooms[depth - 1];
                r     = top / MDC_MAX_ROOM_COLS;
                c     = top % MDC_MAX_ROOM_COLS;
                found = 1'b0;
                for (k = 0; k < 4 && !found; k++) begin
                    d  = order[2*k +: 2];
                    nr = r;
                    nc = c;
                    case (d)
                        DIR_RIGHT: begin
                            nc = c + 1;
                            ok = nc < cols;
                        end
                        DIR_UP: begin
                            nr = r - 1;
                            ok = r > 0 && nr < rows;
                        end
                        DIR_LEFT: begin
                            nc = c - 1;
                            ok = c > 0 && nc < cols;
                        end
                        default: begin
                            nr = r + 1;
                            ok = nr < rows;
                        end
                    endcase
                    slot = nr * MDC_MAX_ROOM_COLS + nc;
                    if (ok && !carved[slot]) begin
                        found              = 1'b1;
                        carved[slot]       = 1'b1;
                        stack_rooms[depth] = slot;
                        depth++;
                        res.event_res = EV_CARVED;
                        res.room_row  = 5'(nr);
                        res.room_col  = 5'(nc);
                        res.direction = d;
                    end
                end
                if (!found) begin
                    depth--;
                    if (depth == 0) begin
                        res.event_res = EV_DONE;
                    end else begin
                        top           = stack_rooms[depth - 1];
                        res.event_res = EV_BACKTRACK;
                        res.room_row  = 5'(top / MDC_MAX_ROOM_COLS);
                        res.room_col  = 5'(top % MDC_MAX_ROOM_COLS);
                    end
                end
            end
            expected_events.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [1:0] ev, logic [15:0] data);
            mdc_result_t want;
            if (expected_events.size() == 0) begin
                $error("event %0d arrived with no command outstanding", ev);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            event_tally[ev]++;
            compare_field("event_res", int'(want.event_res), int'(ev));
            compare_field("room_row", int'(want.room_row), int'(data[4:0]));
            compare_field("room_col", int'(want.room_col), int'(data[9:5]));
            compare_field("direction", int'(want.direction), int'(data[11:10]));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;  // [4:0] perm_index, [7:5] zero
    logic [0:0]        s_tuser  = '0;  // [0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;        // [4:0] room_row, [9:5] room_col,
                                       // [11:10] direction, [15:12] zero
    logic [1:0]        m_tuser;        // [1:0] event_res
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    carve_scoreboard sb;
    int              send_idle  = 0;
    int              recv_stall = 0;
    int              items_sent = 0;
    int              settings   = 0;
    int              cycles     = 0;

    maze_dfs_carver_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // Writes one size register, then reads it back.
    task automatic write_dim(input logic sel, input logic [5:0] value);
        logic [APB_AW-1:0] addr;
        addr = (sel == REG_SEL_COLS) ? COLS_ADDR : ROWS_ADDR;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {26'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_dim(sel, value);
        settings++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.compare_field(sel == REG_SEL_COLS ? "room_cols readback" : "room_rows readback",
                         int'(value), int'(prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(input logic op, input logic [4:0] perm);
        while ($urandom_range(0, 99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, perm};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, perm);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted event has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
    endtask

    task automatic set_size(input logic [5:0] rows, input logic [5:0] cols);
        write_dim(REG_SEL_ROWS, rows);
        write_dim(REG_SEL_COLS, cols);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 74; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 74; end
            default: begin send_idle = 30; recv_stall = 30; end
        endcase
    endtask

    task automatic repeat_steps(input int n, input logic [4:0] perm);
        int k;
        for (k = 0; k < n; k++) send_item(OP_STEP, perm);
    endtask

    // One maze with random direction orders. A resize in the middle leaves
    // rooms on the stack that may now lie outside the grid.
    task automatic run_maze(input logic [5:0] rows, input logic [5:0] cols,
                            input int steps, input bit resize);
        int k;
        set_size(rows, cols);
        send_item(OP_START, 5'($urandom_range(0, 31)));
        for (k = 0; k < steps; k++) begin
            if (resize && k == steps / 2) begin
                drain();
                set_size(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)));
            end
            // A rare restart in the middle of a maze.
            send_item(($urandom_range(0, 99) < 2) ? OP_START : OP_STEP,
                      5'($urandom_range(0, 31)));
        end
        drain();
    endtask

    function automatic logic [5:0] edge_dim();
        case ($urandom_range(0, 3))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            default: return 6'd63;
        endcase
    endfunction

    initial begin
        int         maze_no;
        int         pick;
        logic [5:0] rows, cols;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset size of 8 x 8: a step before any start idles, then a few
        // orders at both ends of the index range, wrapped ones included.
        send_item(OP_STEP, 5'd0);
        send_item(OP_START, 5'd0);
        send_item(OP_STEP, 5'd0);
        send_item(OP_STEP, 5'd23);
        send_item(OP_STEP, 5'd24);
        send_item(OP_STEP, 5'd31);
        send_item(OP_STEP, 5'd6);
        send_item(OP_STEP, 5'd17);
        drain();

        // Zero sizes act as a single room: finish at once, then idle.
        set_size(6'd0, 6'd0);
        send_item(OP_START, 5'd31);
        send_item(OP_STEP, 5'd9);
        send_item(OP_STEP, 5'd30);
        drain();

        // One row of two rooms: carve, backtrack, finish.
        set_size(6'd1, 6'd2);
        send_item(OP_START, 5'd0);
        repeat_steps(3, 5'd0);
        drain();

        // Oversized registers clamp to the grid; then shrink mid-maze.
        set_size(6'd63, 6'd63);
        send_item(OP_START, 5'd0);
        repeat_steps(3, 5'd23);
        drain();
        set_size(6'd2, 6'd2);
        repeat_steps(6, 5'd12);
        drain();

        maze_no = 0;
        while (items_sent < 525) begin
            set_idling(maze_no);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                rows = 6'($urandom_range(1, 6));
                cols = 6'($urandom_range(1, 6));
                run_maze(rows, cols, 2 * int'(rows) * int'(cols) + $urandom_range(0, 3),
                         $urandom_range(0, 99) < 15);
            end else if (pick < 85) begin
                run_maze(edge_dim(), edge_dim(), $urandom_range(10, 70), 1'b0);
            end else begin
                run_maze(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
                         $urandom_range(20, 60), 1'b0);
            end
            maze_no++;
        end

        drain();
        repeat (30) @(posedge aclk);
        $display("Ran %0d commands across %0d mazes with %0d register writes.",
                 items_sent, maze_no + 4, settings);
        $display("Events checked: %0d started, %0d carved, %0d backtracked, %0d finished/idle.",
                 sb.event_tally[EV_STARTED], sb.event_tally[EV_CARVED],
                 sb.event_tally[EV_BACKTRACK], sb.event_tally[EV_DONE]);
        if (sb.failures == 0 && sb.expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
